// ===== design/rcd_pkg.sv =====
// Shared types and constants for the replica coherence directory.
`timescale 1ns / 1ps
package rcd_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int NODE_COUNT  = 4;
   localparam int KEY_BITS    = 48;
   localparam int INDEX_BITS  = 32;
   localparam int SLOTS       = NODE_COUNT + 1;
   localparam int ROW_BITS    = $clog2(TABLE_DEPTH);

   localparam logic [3:0] CMD_LOOKUP       = 4'd0;
   localparam logic [3:0] CMD_DELETE       = 4'd1;
   localparam logic [3:0] CMD_DELETE_LOCAL = 4'd2;
   localparam logic [3:0] CMD_DELETE_IF_RO = 4'd3;
   localparam logic [3:0] CMD_INSERT       = 4'd4;
   localparam logic [3:0] CMD_CHECK_INSERT = 4'd5;
   localparam logic [3:0] CMD_TO_RO        = 4'd6;
   localparam logic [3:0] CMD_TO_RW        = 4'd7;
   localparam logic [3:0] CMD_INVAL_TO_RW  = 4'd8;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_SLOT_FAIL   = 3'd1;
   localparam logic [2:0] ST_WMETA_FAIL  = 3'd2;
   localparam logic [2:0] ST_NO_ENTRY    = 3'd3;
   localparam logic [2:0] ST_WMETA_VALID = 3'd4;
   localparam logic [2:0] ST_ALREADY     = 3'd5;
   localparam logic [2:0] ST_VIOLATION   = 3'd6;
   localparam logic [2:0] ST_FULL        = 3'd7;

   typedef struct packed {
      logic [3:0]            cmd;
      logic [KEY_BITS-1:0]   block_key;
      logic [2:0]            node;
      logic [INDEX_BITS-1:0] replica_in;
      logic                  wmeta_in_valid;
      logic [INDEX_BITS-1:0] wmeta_in;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic                  found;
      logic                  removed;
      logic                  wmeta_out_valid;
      logic [INDEX_BITS-1:0] wmeta_out;
      logic [SLOTS-1:0]      replica_mask;
      logic [SLOTS-1:0]      invalid_mask;
      logic [INDEX_BITS-1:0] replica_out;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic                  inval;
      logic [INDEX_BITS-1:0] idx;
   } slot_type;

   typedef struct packed {
      logic                  wvalid;
      logic [INDEX_BITS-1:0] wval;
      slot_type [SLOTS-1:0]  slot;
   } row_type;

   // search token that walks the chain
   typedef struct packed {
      logic                valid;
      req_type             req;
      logic                match;
      logic [ROW_BITS-1:0] match_idx;
      row_type             row;
      logic                free_found;
      logic [ROW_BITS-1:0] free_idx;
   } tok_type;

   // row write broadcast from the controller
   typedef struct packed {
      logic                en;
      logic [ROW_BITS-1:0] idx;
      logic                used;
      logic [KEY_BITS-1:0] key;
      row_type             row;
   } wr_type;

endpackage

// ===== design/rcd_cell.sv =====
// One directory row: holds its entry and forwards the search token.
`timescale 1ns / 1ps
module rcd_cell
   import rcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [ROW_BITS-1:0] my_idx,
   input  tok_type             tok_in,
   input  wr_type              wr,
   output tok_type             tok_out
);

   logic                used_ff;
   logic [KEY_BITS-1:0] key_ff;
   row_type             row_ff;
   tok_type             tok_ff, tok_in_n;

   always_comb begin
      tok_in_n = tok_in;
      if (used_ff && key_ff == tok_in.req.block_key) begin
         tok_in_n.match     = 1'b1;
         tok_in_n.match_idx = my_idx;
         tok_in_n.row       = row_ff;
      end
      if (!used_ff && !tok_in.free_found) begin
         tok_in_n.free_found = 1'b1;
         tok_in_n.free_idx   = my_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
         if (wr.en && wr.idx == my_idx) begin
            used_ff <= wr.used;
         end
      end
      if (wr.en && wr.idx == my_idx) begin
         key_ff <= wr.key;
         row_ff <= wr.row;
      end
      {tok_ff.req, tok_ff.match, tok_ff.match_idx, tok_ff.row, tok_ff.free_found,
       tok_ff.free_idx} <= {tok_in_n.req, tok_in_n.match, tok_in_n.match_idx,
                            tok_in_n.row, tok_in_n.free_found, tok_in_n.free_idx};
   end

   assign tok_out = tok_ff;

endmodule

// ===== design/replica_coherence_directory.sv =====
// Top level: coherence directory built as a chain of row cells.
`timescale 1ns / 1ps
// Usage notes
// req_ channel: one command beat (req_data) accepted when req_valid and
//   req_ready are high. req_ready is low while a command is in flight.
// rsp_ channel: one result beat per command, held in rsp_data until taken.
// Each command sends a search token down the chain of TABLE_DEPTH row cells,
//   one cell per cycle; the token gathers the matching row and the lowest
//   free row. At the end of the chain the row update is worked out and
//   written back to the chosen cell.
// The token passes every cell's token register and then the hold register;
//   the result is registered when the row update is processed. One command
//   at a time: the next beat is taken only once the result has been
//   registered, which waits while a previous result has not been taken.
// Reset empties the table (every cell's used bit cleared) and drops any
//   beat in flight; it is then ready for a command.
// When the receiver stalls, the finished token waits at the end of the chain
//   and the table is not touched until the pending result has been taken.
module replica_coherence_directory
   import rcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   tok_type tok [TABLE_DEPTH+1];
   wr_type  wr;

   logic    busy_ff, busy_in;
   logic    hold_v_ff, hold_v_in;
   tok_type hold_ff;
   logic    rsp_v_ff, rsp_v_in;
   rsp_type rsp_ff, rsp_in;
   logic    accept, process;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign process   = hold_v_ff && (!rsp_v_ff || rsp_ready);

   always_comb begin
      tok[0]       = '0;
      tok[0].valid = accept;
      tok[0].req   = req_data;
   end

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         rcd_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .my_idx  (ROW_BITS'(g)),
            .tok_in  (tok[g]),
            .wr      (wr),
            .tok_out (tok[g+1])
         );
      end
   endgenerate

   // row update and result
   always_comb begin
      req_type         q;
      row_type         nr;
      logic            found, node_ok, removed, have_row, any_rep;
      logic [2:0]      sidx;
      logic [2:0]      st;
      q        = hold_ff.req;
      found    = hold_ff.match;
      nr       = hold_ff.row;
      node_ok  = q.node <= 3'(NODE_COUNT);
      sidx     = node_ok ? q.node : 3'd0;
      st       = ST_OK;
      removed  = 1'b0;
      have_row = found;
      any_rep  = 1'b0;
      wr       = '0;
      wr.idx   = hold_ff.match_idx;
      wr.used  = 1'b1;
      wr.key   = q.block_key;

      if (q.cmd > CMD_INVAL_TO_RW ||
          (q.cmd >= CMD_DELETE_LOCAL && q.cmd <= CMD_CHECK_INSERT && !node_ok)) begin
         st = ST_VIOLATION;
      end else if (q.cmd == CMD_LOOKUP) begin
         if (!found) st = ST_NO_ENTRY;
      end else if (!found && q.cmd != CMD_INSERT && q.cmd != CMD_CHECK_INSERT) begin
         st = ST_NO_ENTRY;
      end else begin
         case (q.cmd)
            CMD_DELETE: begin
               removed = 1'b1;
            end
            CMD_DELETE_LOCAL: begin
               nr.slot[sidx] = '0;
               wr.en = 1'b1;
            end
            CMD_DELETE_IF_RO: begin
               if (q.node == 3'd0 && nr.wvalid) begin
                  st = ST_WMETA_VALID;
               end else if (!nr.slot[sidx].valid && !nr.slot[sidx].inval) begin
                  st = ST_ALREADY;
               end else begin
                  nr.slot[sidx] = '0;
                  wr.en = 1'b1;
               end
            end
            CMD_INSERT, CMD_CHECK_INSERT: begin
               if (!found) begin
                  if (!hold_ff.free_found) begin
                     st = ST_FULL;
                  end else begin
                     have_row = 1'b1;
                     nr = '0;
                     nr.slot[sidx].valid = 1'b1;
                     nr.slot[sidx].idx   = q.replica_in;
                     if (q.cmd == CMD_CHECK_INSERT && q.node == 3'd0) begin
                        nr.wvalid = q.wmeta_in_valid;
                        nr.wval   = q.wmeta_in_valid ? q.wmeta_in : '0;
                     end
                     wr.en  = 1'b1;
                     wr.idx = hold_ff.free_idx;
                  end
               end else if (q.cmd == CMD_INSERT) begin
                  nr.slot[sidx].valid = 1'b1;
                  nr.slot[sidx].inval = 1'b0;
                  nr.slot[sidx].idx   = q.replica_in;
                  nr.wvalid = 1'b0;
                  nr.wval   = '0;
                  wr.en = 1'b1;
               end else if (!nr.slot[sidx].valid) begin
                  if (nr.slot[sidx].inval || (nr.wvalid && q.node != 3'd0)) begin
                     st = ST_VIOLATION;
                  end else begin
                     nr.slot[sidx].valid = 1'b1;
                     nr.slot[sidx].inval = 1'b0;
                     nr.slot[sidx].idx   = q.replica_in;
                     if (q.node == 3'd0) begin
                        nr.wvalid = q.wmeta_in_valid;
                        nr.wval   = q.wmeta_in_valid ? q.wmeta_in : '0;
                     end
                     wr.en = 1'b1;
                  end
               end else if (q.node == 3'd0) begin
                  if (!q.wmeta_in_valid) begin
                     nr.wvalid = 1'b0;
                     nr.wval   = '0;
                     st = ST_SLOT_FAIL;
                     wr.en = 1'b1;
                  end else if (!nr.wvalid) begin
                     nr.wvalid = 1'b1;
                     nr.wval   = q.wmeta_in;
                     st = ST_SLOT_FAIL;
                     wr.en = 1'b1;
                  end else begin
                     st = ST_WMETA_FAIL;
                  end
               end
            end
            CMD_TO_RO: begin
               nr.wvalid = 1'b0;
               nr.wval   = '0;
               wr.en = 1'b1;
            end
            CMD_TO_RW: begin
               if (!nr.wvalid) begin
                  nr.wvalid = 1'b1;
                  nr.wval   = q.wmeta_in;
               end
               wr.en = 1'b1;
            end
            default: begin
               // invalidate every remote replica
               for (int s = 1; s < SLOTS; s++) begin
                  if (nr.slot[s].valid) nr.slot[s].inval = 1'b1;
               end
               if (!nr.wvalid) begin
                  nr.wvalid = 1'b1;
                  nr.wval   = q.wmeta_in;
               end else begin
                  st = ST_WMETA_FAIL;
               end
               wr.en = 1'b1;
            end
         endcase
         if (q.cmd == CMD_DELETE_LOCAL ||
             (q.cmd == CMD_DELETE_IF_RO && wr.en)) begin
            for (int s = 0; s < SLOTS; s++) begin
               if (nr.slot[s].valid) any_rep = 1'b1;
            end
            removed = !any_rep;
         end
      end

      if (removed) begin
         wr.en   = 1'b1;
         wr.used = 1'b0;
      end
      wr.row = nr;
      wr.en  = wr.en && process;

      rsp_in        = '0;
      rsp_in.status = st;
      rsp_in.found  = found;
      rsp_in.removed = removed;
      if (removed) begin
         rsp_in.wmeta_out_valid = hold_ff.row.wvalid;
         rsp_in.wmeta_out       = hold_ff.row.wval;
      end else if (have_row) begin
         rsp_in.wmeta_out_valid = nr.wvalid;
         rsp_in.wmeta_out       = nr.wval;
         for (int s = 0; s < SLOTS; s++) begin
            rsp_in.replica_mask[s] = nr.slot[s].valid;
            rsp_in.invalid_mask[s] = nr.slot[s].inval;
         end
         if (node_ok && nr.slot[sidx].valid) rsp_in.replica_out = nr.slot[sidx].idx;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      hold_v_in = hold_v_ff;
      rsp_v_in  = rsp_v_ff;
      if (rsp_v_ff && rsp_ready) rsp_v_in = 1'b0;
      if (accept) busy_in = 1'b1;
      if (tok[TABLE_DEPTH].valid) hold_v_in = 1'b1;
      if (process) begin
         hold_v_in = 1'b0;
         busy_in   = 1'b0;
         rsp_v_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
      if (tok[TABLE_DEPTH].valid) hold_ff <= tok[TABLE_DEPTH];
      if (process) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/rcd_checker.sv =====
// Checker for the replica coherence directory: predicts every result and compares it.
`timescale 1ns / 1ps
module rcd_checker
   import rcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);

   // shadow directory
   logic                  row_used  [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   row_key   [TABLE_DEPTH];
   logic                  row_wv    [TABLE_DEPTH];
   logic [INDEX_BITS-1:0] row_wval  [TABLE_DEPTH];
   logic                  slot_rep  [TABLE_DEPTH][SLOTS];
   logic                  slot_mark [TABLE_DEPTH][SLOTS];
   logic [INDEX_BITS-1:0] slot_idx  [TABLE_DEPTH][SLOTS];

   rsp_type expected_rsp_q[$];

   function automatic logic row_empty(input int r);
      for (int s = 0; s < SLOTS; s++)
         if (slot_rep[r][s]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void clear_slot(input int r, input int s);
      slot_rep[r][s]  = 1'b0;
      slot_mark[r][s] = 1'b0;
      slot_idx[r][s]  = '0;
   endfunction

   function automatic rsp_type predict_directory(input req_type q);
      int                    r;
      int                    n;
      logic                  found;
      logic                  nok;
      logic                  removed;
      logic [2:0]            st;
      logic                  old_wv;
      logic [INDEX_BITS-1:0] old_wval;
      rsp_type               e;
      n        = q.node;
      nok      = (n <= NODE_COUNT);
      r        = -1;
      st       = ST_OK;
      removed  = 1'b0;
      old_wv   = 1'b0;
      old_wval = '0;
      e        = '0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (r < 0 && row_used[i] && row_key[i] == q.block_key) r = i;
      found = (r >= 0);
      if (found) begin
         old_wv   = row_wv[r];
         old_wval = row_wval[r];
      end
      if (q.cmd > CMD_INVAL_TO_RW ||
          (q.cmd >= CMD_DELETE_LOCAL && q.cmd <= CMD_CHECK_INSERT && !nok)) begin
         st = ST_VIOLATION;
      end else if (q.cmd == CMD_LOOKUP) begin
         if (!found) st = ST_NO_ENTRY;
      end else if (!found && q.cmd != CMD_INSERT && q.cmd != CMD_CHECK_INSERT) begin
         st = ST_NO_ENTRY;
      end else begin
         case (q.cmd)
            CMD_DELETE: begin
               removed = 1'b1;
            end
            CMD_DELETE_LOCAL: begin
               clear_slot(r, n);
               removed = row_empty(r);
            end
            CMD_DELETE_IF_RO: begin
               if (n == 0 && row_wv[r]) st = ST_WMETA_VALID;
               else if (!slot_rep[r][n] && !slot_mark[r][n]) st = ST_ALREADY;
               else begin
                  clear_slot(r, n);
                  removed = row_empty(r);
               end
            end
            CMD_INSERT, CMD_CHECK_INSERT: begin
               if (!found) begin
                  for (int i = 0; i < TABLE_DEPTH; i++)
                     if (r < 0 && !row_used[i]) r = i;
                  if (r < 0) st = ST_FULL;
                  else begin
                     row_used[r] = 1'b1;
                     row_key[r]  = q.block_key;
                     row_wv[r]   = 1'b0;
                     row_wval[r] = '0;
                     for (int s = 0; s < SLOTS; s++) clear_slot(r, s);
                     slot_rep[r][n] = 1'b1;
                     slot_idx[r][n] = q.replica_in;
                     if (q.cmd == CMD_CHECK_INSERT && n == 0) begin
                        row_wv[r]   = q.wmeta_in_valid;
                        row_wval[r] = q.wmeta_in_valid ? q.wmeta_in : '0;
                     end
                  end
               end else if (q.cmd == CMD_INSERT) begin
                  slot_rep[r][n]  = 1'b1;
                  slot_mark[r][n] = 1'b0;
                  slot_idx[r][n]  = q.replica_in;
                  row_wv[r]       = 1'b0;
                  row_wval[r]     = '0;
               end else if (!slot_rep[r][n]) begin
                  if (slot_mark[r][n] || (row_wv[r] && n != 0)) st = ST_VIOLATION;
                  else begin
                     slot_rep[r][n]  = 1'b1;
                     slot_mark[r][n] = 1'b0;
                     slot_idx[r][n]  = q.replica_in;
                     if (n == 0) begin
                        row_wv[r]   = q.wmeta_in_valid;
                        row_wval[r] = q.wmeta_in_valid ? q.wmeta_in : '0;
                     end
                  end
               end else if (n == 0) begin
                  if (!q.wmeta_in_valid) begin
                     row_wv[r]   = 1'b0;
                     row_wval[r] = '0;
                     st          = ST_SLOT_FAIL;
                  end else if (!row_wv[r]) begin
                     row_wv[r]   = 1'b1;
                     row_wval[r] = q.wmeta_in;
                     st          = ST_SLOT_FAIL;
                  end else st = ST_WMETA_FAIL;
               end
            end
            CMD_TO_RO: begin
               row_wv[r]   = 1'b0;
               row_wval[r] = '0;
            end
            CMD_TO_RW: begin
               if (!row_wv[r]) begin
                  row_wv[r]   = 1'b1;
                  row_wval[r] = q.wmeta_in;
               end
            end
            default: begin
               for (int s = 1; s < SLOTS; s++)
                  if (slot_rep[r][s]) slot_mark[r][s] = 1'b1;
               if (!row_wv[r]) begin
                  row_wv[r]   = 1'b1;
                  row_wval[r] = q.wmeta_in;
               end else st = ST_WMETA_FAIL;
            end
         endcase
      end
      e.status  = st;
      e.found   = found;
      e.removed = removed;
      if (removed) begin
         row_used[r]       = 1'b0;
         e.wmeta_out_valid = old_wv;
         e.wmeta_out       = old_wval;
      end else if (r >= 0) begin
         e.wmeta_out_valid = row_wv[r];
         e.wmeta_out       = row_wval[r];
         for (int s = 0; s < SLOTS; s++) begin
            e.replica_mask[s] = slot_rep[r][s];
            e.invalid_mask[s] = slot_mark[r][s];
         end
         if (nok && slot_rep[r][n]) e.replica_out = slot_idx[r][n];
      end
      return e;
   endfunction

   assign pending = expected_rsp_q.size();

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         errors <= 0;
         expected_rsp_q.delete();
         for (int i = 0; i < TABLE_DEPTH; i++) row_used[i] = 1'b0;
      end else begin
         if (req_valid && req_ready) expected_rsp_q.push_back(predict_directory(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("%0t: result beat with nothing expected", $realtime);
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.status !== exp_rsp.status || rsp_data.found !== exp_rsp.found ||
                   rsp_data.removed !== exp_rsp.removed ||
                   rsp_data.wmeta_out_valid !== exp_rsp.wmeta_out_valid ||
                   rsp_data.wmeta_out !== exp_rsp.wmeta_out ||
                   rsp_data.replica_mask !== exp_rsp.replica_mask ||
                   rsp_data.invalid_mask !== exp_rsp.invalid_mask ||
                   rsp_data.replica_out !== exp_rsp.replica_out) begin
                  errors <= errors + 1;
                  if (errors < 10) begin
                     $write("%0t: mismatch st/fd/rm/wv/wm/rmask/imask/rep exp %0d %b %b %b %h %b %b %h",
                        $realtime, exp_rsp.status, exp_rsp.found, exp_rsp.removed,
                        exp_rsp.wmeta_out_valid, exp_rsp.wmeta_out, exp_rsp.replica_mask,
                        exp_rsp.invalid_mask, exp_rsp.replica_out);
                     $display(" act %0d %b %b %b %h %b %b %h",
                        rsp_data.status, rsp_data.found, rsp_data.removed,
                        rsp_data.wmeta_out_valid, rsp_data.wmeta_out, rsp_data.replica_mask,
                        rsp_data.invalid_mask, rsp_data.replica_out);
                  end
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb_replica_coherence_directory.sv =====
// Testbench top: drives commands into the directory and reports the verdict.
`timescale 1ns / 1ps
module tb_replica_coherence_directory;
   import rcd_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      errors;
   int      pending;

   int send_gap_pct  = 0;   // chance of an idle stretch after each command beat
   int rsp_stall_pct = 0;   // chance the receiver holds off in a given cycle
   int beats_sent    = 0;

   // a small pool of keys so rows are hit again and again; the extremes included
   logic [KEY_BITS-1:0] key_pool [12];

   always #10 clock = ~clock;

   replica_coherence_directory u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rcd_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // present one command beat and hold it until accepted; valid stays high
   // into the next beat unless an idle stretch is drawn
   task automatic send_command(input logic [3:0] cmd, input logic [KEY_BITS-1:0] key,
                               input logic [2:0] node, input logic [INDEX_BITS-1:0] rep,
                               input logic wv, input logic [INDEX_BITS-1:0] wm);
      req_type b;
      b.cmd            = cmd;
      b.block_key      = key;
      b.node           = node;
      b.replica_in     = rep;
      b.wmeta_in_valid = wv;
      b.wmeta_in       = wm;
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [INDEX_BITS-1:0] pick_index();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // random command: mostly pool keys and in-range nodes, inserts weighted up
   task automatic send_random();
      logic [3:0]          cmd;
      logic [KEY_BITS-1:0] key;
      logic [2:0]          node;
      int                  roll;
      roll = $urandom_range(99);
      if (roll < 4) cmd = 4'($urandom_range(15, 9));
      else if (roll < 34) cmd = ($urandom_range(1)) ? CMD_INSERT : CMD_CHECK_INSERT;
      else cmd = 4'($urandom_range(8));
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(11)];
      else key = KEY_BITS'({$urandom, $urandom});
      node = ($urandom_range(99) < 10) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_command(cmd, key, node, pick_index(), 1'($urandom_range(1)), pick_index());
   endtask

   initial begin
      int gap_tab   [4] = '{0, 50, 0, 6};
      int stall_tab [4] = '{0, 0, 50, 6};
      logic [KEY_BITS-1:0] k0;
      logic [KEY_BITS-1:0] k1;
      logic [KEY_BITS-1:0] fill_base;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 12; i++) key_pool[i] = KEY_BITS'({$urandom, $urandom});
      k0 = key_pool[0];
      k1 = key_pool[1];
      fill_base = 48'h5A00_0000_0000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty directory, write-metadata handling, marks, removals
      send_command(CMD_LOOKUP,       k0, 3'd0, '0, 1'b0, '0);
      send_command(CMD_DELETE,       k0, 3'd0, '0, 1'b0, '0);
      send_command(CMD_TO_RO,        k0, 3'd0, '0, 1'b0, '0);
      send_command(CMD_CHECK_INSERT, k0, 3'd0, '1, 1'b1, '1);
      send_command(CMD_CHECK_INSERT, k0, 3'd0, '1, 1'b1, 32'h1234);  // wmeta held
      send_command(CMD_CHECK_INSERT, k0, 3'd2, 32'h22, 1'b0, '0);    // rw row, remote
      send_command(CMD_CHECK_INSERT, k0, 3'd0, '1, 1'b0, '0);        // drops wmeta
      send_command(CMD_CHECK_INSERT, k0, 3'd0, '1, 1'b1, 32'h55);    // sets wmeta
      send_command(CMD_TO_RO,        k0, 3'd0, '0, 1'b0, '0);
      send_command(CMD_CHECK_INSERT, k0, 3'd3, '0, 1'b0, '0);
      send_command(CMD_CHECK_INSERT, k0, 3'd3, 32'h9, 1'b0, '0);     // slot full
      send_command(CMD_INVAL_TO_RW,  k0, 3'd0, '0, 1'b0, '0);
      send_command(CMD_INVAL_TO_RW,  k0, 3'd0, '0, 1'b0, '1);        // wmeta present
      send_command(CMD_CHECK_INSERT, k0, 3'd4, 32'h4, 1'b0, '0);
      send_command(CMD_DELETE_IF_RO, k0, 3'd0, '0, 1'b0, '0);        // home, rw
      send_command(CMD_TO_RO,        k0, 3'd0, '0, 1'b0, '0);
      send_command(CMD_TO_RW,        k0, 3'd0, '0, 1'b0, 32'h77);
      send_command(CMD_INSERT,       k1, 3'd7, '1, 1'b0, '0);        // node out of range
      send_command(CMD_LOOKUP,       k0, 3'd7, '0, 1'b0, '0);
      send_command(CMD_DELETE_LOCAL, k0, 3'd3, '0, 1'b0, '0);
      send_command(CMD_DELETE_IF_RO, k0, 3'd3, '0, 1'b0, '0);        // already gone
      send_command(CMD_INSERT,       k1, 3'd4, '1, 1'b1, '1);
      send_command(CMD_DELETE_IF_RO, k1, 3'd4, '0, 1'b0, '0);        // frees the row
      send_command(4'd15,            k0, 3'd0, '0, 1'b0, '0);
      send_command(CMD_DELETE,       k0, 3'd0, '0, 1'b0, '0);

      // random traffic under each idling pattern
      for (int p = 0; p < 4; p++) begin
         send_gap_pct  = gap_tab[p];
         rsp_stall_pct = stall_tab[p];
         repeat (60) send_random();
      end

      // fill the table past its depth, then empty the fresh rows again
      send_gap_pct  = 6;
      rsp_stall_pct = 6;
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_command(CMD_INSERT, fill_base + i, 3'($urandom_range(4)), $urandom, 1'b0, '0);
      send_command(CMD_CHECK_INSERT, fill_base + TABLE_DEPTH, 3'd0, '1, 1'b1, '1);
      send_command(CMD_INSERT, fill_base + TABLE_DEPTH + 1, 3'd1, '1, 1'b0, '0);
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_command(CMD_DELETE, fill_base + i, 3'd0, '0, 1'b0, '0);
      repeat (40) send_random();

      req_valid     <= 1'b0;
      rsp_stall_pct = 0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Sent %0d command beats: directed cases, four idling patterns, table fill",
               beats_sent);
      $display("and drain; every result compared field by field with the prediction.");
      if (errors == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run (about 820 beats)
   initial begin
      #50ms;
      $display("Timeout with %0d results outstanding", pending);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
